### rtl/mbrtu_pkg.sv
// Shared constants for the Modbus RTU read-holding-registers master.
`default_nettype none

package mbrtu_pkg;

  // Input word kinds (s_tuser)
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_RXBYTE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // Output word kinds (m_tuser)
  localparam logic [1:0] KIND_TX = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Final status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FRAME = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_CRC = 3'd3;
  localparam logic [2:0] ST_EXC = 3'd4;

  // Register indexes (paddr[2])
  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [7:0] FUNC_READ = 8'h03;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] DEV_ADDR_RESET = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [17:0] REPLY_OVERHEAD = 18'd5;

endpackage

`default_nettype wire

### rtl/modbus_rtu_read_holding_master_core.sv
// Modbus RTU master core for function 0x03 (read holding registers).
`default_nettype none

// The core takes one input word at a time (s_tuser selects a request, a received
// serial byte or a one millisecond tick) and returns result words on the master
// stream: request bytes to transmit, register words, and one final status word
// marked by m_tlast. A request runs the CRC-16 bit-serially over the six header
// bytes (one bit per cycle through a shift register), then offers the eight
// frame bytes, one per cycle while the sink takes them. A received byte that is
// covered by the CRC runs through the same one-bit CRC step. When the reply is
// complete, the check runs, and each register word is then read through the
// single read port of the reply buffer (two byte reads with registered data).
// A finished result waits in the output register while the next input word is
// taken. The reply buffer holds MAX_FRAME_BYTES bytes and needs no clearing
// after reset.
module modbus_rtu_read_holding_master_core #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // start_reg[15:0], reg_count[31:16], rx_byte[39:32]
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // tx_byte[7:0], reg_index[12:8], reg_word[28:13],
                                      // status[31:29]
  output logic [1:0]       m_tuser,   // out_kind[1:0]
  output logic             m_tlast,   // last
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mbrtu_pkg::*;

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int BW = $clog2(MAX_FRAME_BYTES + 1);

  typedef enum logic [8:0] {
    S_READY   = 9'b000000001,
    S_REQ_CRC = 9'b000000010,
    S_REQ_TX  = 9'b000000100,
    S_RX_CRC  = 9'b000001000,
    S_CHECK   = 9'b000010000,
    S_RD_HI   = 9'b000100000,
    S_RD_LO   = 9'b001000000,
    S_EMIT    = 9'b010000000,
    S_STATUS  = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0]  dev_addr;
  logic [15:0] timeout;

  // run state
  logic          receiving;
  logic [BW-1:0] bytes_received;
  logic [BW-1:0] reply_length;
  logic [AW-1:0] pending;
  logic [15:0]   elapsed;
  logic [15:0]   crc;
  logic [15:0]   req_start;
  logic [15:0]   req_count;
  logic          too_long;
  logic [7:0]    sh;
  logic [2:0]    bit_cnt;
  logic [2:0]    byte_idx;
  logic [2:0]    st_code;
  logic [7:0]    hdr_addr, hdr_func, hdr_cnt;
  logic [7:0]    b_last, b_prev;
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] widx;
  logic [7:0]    hi_byte;

  // reply buffer
  logic [7:0]    mem [MAX_FRAME_BYTES];
  logic [7:0]    mem_rdata;
  logic          mem_we;

  // output register
  logic [1:0]  out_kind;
  logic [7:0]  out_tx;
  logic [4:0]  out_idx;
  logic [15:0] out_word;
  logic [2:0]  out_status;
  logic        out_last;

  // input fields
  logic [1:0]  in_type;
  logic [15:0] in_start, in_count;
  logic [7:0]  in_byte;
  logic        in_acc, out_free, out_load;

  assign in_type  = s_tuser;
  assign in_start = s_tdata[15:0];
  assign in_count = s_tdata[31:16];
  assign in_byte  = s_tdata[39:32];

  assign s_tready = (state == S_READY);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == S_REQ_TX || state == S_EMIT || state == S_STATUS);

  assign m_tdata = {out_status, out_word, out_idx, out_tx};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  // Configuration port: decode by word address, ignore byte lanes.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout} : {24'd0, dev_addr};

  // One CRC-16 bit step: feed the low bit of the shift register.
  logic        crc_fb;
  logic [15:0] crc_next;
  assign crc_fb   = crc[0] ^ sh[0];
  assign crc_next = {1'b0, crc[15:1]} ^ (crc_fb ? CRC_POLY : 16'd0);

  // Request frame byte selected by position.
  logic [7:0] frame_byte;
  logic [2:0] frame_sel;
  always_comb begin
    unique case (frame_sel)
      3'd0: frame_byte = dev_addr;
      3'd1: frame_byte = FUNC_READ;
      3'd2: frame_byte = req_start[15:8];
      3'd3: frame_byte = req_start[7:0];
      3'd4: frame_byte = req_count[15:8];
      3'd5: frame_byte = req_count[7:0];
      3'd6: frame_byte = crc[7:0];
      default: frame_byte = crc[15:8];
    endcase
  end
  assign frame_sel = (state == S_REQ_CRC) ? byte_idx + 3'd1 : byte_idx;

  // Request length arithmetic.
  logic [17:0] exp_len;
  logic        exp_too_long;
  assign exp_len      = REPLY_OVERHEAD + {1'b0, in_count, 1'b0};
  assign exp_too_long = exp_len > 18'(MAX_FRAME_BYTES);

  // Receive byte bookkeeping.
  logic          byte_ok;
  logic [BW-1:0] rcv_next;
  logic          rcv_done;
  logic          rcv_crc;
  assign byte_ok  = receiving && (bytes_received < reply_length)
                    && (bytes_received < BW'(MAX_FRAME_BYTES));
  assign rcv_next = bytes_received + BW'(1);
  assign rcv_done = (rcv_next == reply_length);
  assign rcv_crc  = ({1'b0, bytes_received} + (BW + 1)'(2)) < {1'b0, reply_length};
  assign mem_we   = in_acc && (in_type == REQ_RXBYTE) && byte_ok;

  // Saturating tick count.
  logic [15:0] elapsed_next;
  assign elapsed_next = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;

  // Reply checks.
  logic crc_bad, hdr_bad, cnt_bad;
  assign crc_bad = crc != {b_last, b_prev};
  assign hdr_bad = (hdr_addr != dev_addr) || (hdr_func != FUNC_READ);
  assign cnt_bad = 16'(hdr_cnt) != 16'({pending, 1'b0});

  // Reply buffer: write on each stored byte, read for word assembly.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[bytes_received[AW-1:0]] <= in_byte;
    end
    if (state == S_RD_HI || state == S_RD_LO) begin
      mem_rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_READY;
      m_tvalid       <= 1'b0;
      dev_addr       <= DEV_ADDR_RESET;
      timeout        <= TIMEOUT_RESET;
      receiving      <= 1'b0;
      bytes_received <= '0;
      reply_length   <= '0;
      pending        <= '0;
      elapsed        <= '0;
      crc            <= CRC_INIT;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_DEV_ADDR) begin
          dev_addr <= pwdata[7:0];
        end else begin
          timeout <= pwdata[15:0];
        end
      end

      // Raise the output word on a load; drop it once taken.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_READY: begin
          if (in_acc) begin
            priority if (in_type == REQ_START) begin
              // Abandon any reply in progress and start over.
              receiving      <= 1'b0;
              bytes_received <= '0;
              elapsed        <= '0;
              req_start      <= in_start;
              req_count      <= in_count;
              if (in_count == 16'd0) begin
                st_code <= ST_FRAME;
                state   <= S_STATUS;
              end else begin
                crc          <= CRC_INIT;
                sh           <= dev_addr;
                bit_cnt      <= '0;
                byte_idx     <= '0;
                too_long     <= exp_too_long;
                reply_length <= BW'(exp_len);
                pending      <= AW'(in_count);
                state        <= S_REQ_CRC;
              end
            end else if (in_type == REQ_RXBYTE) begin
              if (byte_ok) begin
                bytes_received <= rcv_done ? BW'(0) : rcv_next;
                b_last         <= in_byte;
                b_prev         <= b_last;
                if (bytes_received == BW'(0)) hdr_addr <= in_byte;
                if (bytes_received == BW'(1)) hdr_func <= in_byte;
                if (bytes_received == BW'(2)) hdr_cnt  <= in_byte;
                if (rcv_crc) begin
                  sh      <= in_byte;
                  bit_cnt <= '0;
                  state   <= S_RX_CRC;
                end else if (rcv_done) begin
                  // Close the receive window; the buffer keeps the reply.
                  receiving <= 1'b0;
                  elapsed   <= '0;
                  state     <= S_CHECK;
                end
              end
            end else if (in_type == REQ_TICK) begin
              if (receiving) begin
                if (elapsed_next >= timeout) begin
                  receiving      <= 1'b0;
                  bytes_received <= '0;
                  elapsed        <= '0;
                  st_code        <= ST_TIMEOUT;
                  state          <= S_STATUS;
                end else begin
                  elapsed <= elapsed_next;
                end
              end
            end else begin
              // unused kind: nothing to do
            end
          end
        end

        S_REQ_CRC: begin
          crc     <= crc_next;
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            if (byte_idx == 3'd5) begin
              byte_idx <= '0;
              state    <= S_REQ_TX;
            end else begin
              byte_idx <= byte_idx + 3'd1;
              sh       <= frame_byte;
            end
          end else begin
            sh <= {1'b0, sh[7:1]};
          end
        end

        S_REQ_TX: begin
          if (out_free) begin
            out_kind   <= KIND_TX;
            out_tx     <= frame_byte;
            out_idx    <= '0;
            out_word   <= '0;
            out_status <= ST_OK;
            out_last   <= 1'b0;
            byte_idx   <= byte_idx + 3'd1;
            if (byte_idx == 3'd7) begin
              priority if (too_long) begin
                st_code <= ST_FRAME;
                state   <= S_STATUS;
              end else if (timeout == 16'd0) begin
                st_code <= ST_TIMEOUT;
                state   <= S_STATUS;
              end else begin
                receiving <= 1'b1;
                crc       <= CRC_INIT;
                state     <= S_READY;
              end
            end
          end
        end

        S_RX_CRC: begin
          crc     <= crc_next;
          sh      <= {1'b0, sh[7:1]};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= S_READY;
          end
        end

        S_CHECK: begin
          rd_ptr <= AW'(3);
          widx   <= '0;
          priority if (crc_bad) begin
            st_code <= ST_CRC;
            state   <= S_STATUS;
          end else if (hdr_bad) begin
            st_code <= hdr_func[7] ? ST_EXC : ST_FRAME;
            state   <= S_STATUS;
          end else if (cnt_bad) begin
            st_code <= ST_FRAME;
            state   <= S_STATUS;
          end else begin
            state <= S_RD_HI;
          end
        end

        S_RD_HI: begin
          rd_ptr <= rd_ptr + AW'(1);
          state  <= S_RD_LO;
        end

        S_RD_LO: begin
          hi_byte <= mem_rdata;
          rd_ptr  <= rd_ptr + AW'(1);
          state   <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_kind   <= KIND_WORD;
            out_tx     <= '0;
            out_idx    <= 5'(widx);
            out_word   <= {hi_byte, mem_rdata};
            out_status <= ST_OK;
            out_last   <= 1'b0;
            widx       <= widx + AW'(1);
            if (widx + AW'(1) == pending) begin
              st_code <= ST_OK;
              state   <= S_STATUS;
            end else begin
              state <= S_RD_HI;
            end
          end
        end

        S_STATUS: begin
          if (out_free) begin
            out_kind   <= KIND_STATUS;
            out_tx     <= '0;
            out_idx    <= '0;
            out_word   <= '0;
            out_status <= st_code;
            out_last   <= 1'b1;
            receiving  <= 1'b0;
            crc        <= CRC_INIT;
            state      <= S_READY;
          end
        end

        default: begin
          state <= S_READY;
        end
      endcase
    end
  end

  // The receive count never reaches the expected length while listening.
  a_rx_bounded: assert property (@(posedge clk) disable iff (rst)
    receiving |-> bytes_received < reply_length)
    else $error("receive count reached reply length while listening");

  // Counters are cleared whenever no reply is awaited.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !receiving |-> (bytes_received == '0) && (elapsed == '0))
    else $error("receive counters not cleared outside a reply");

  // Only a status word closes a run.
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == KIND_STATUS)
    else $error("last marker on a non-status word");

  // Header CRC covers exactly six bytes.
  a_crc_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == S_REQ_CRC) |-> byte_idx <= 3'd5)
    else $error("request CRC ran past the header");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register lost its one-hot code");

endmodule

`default_nettype wire
